// ----- hdl/pimrp_pkg.sv -----
// ----------------------------------------------------------------------------
// pimrp_pkg
// Shared types, constants and command codes for the point-in-mesh ray parity
// block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pimrp_pkg;

  // Default width of the saturating crossing counter
  localparam int COUNT_WIDTH_DEF = 16;

  // Arithmetic widths
  localparam int VW  = 33;   // edge / offset vector component
  localparam int PW  = 67;   // det, u and Q components
  localparam int MW  = 35;   // multiplier operand
  localparam int XW  = 70;   // multiplier product
  localparam int AW  = 104;  // accumulator
  localparam int QLO = 34;   // low slice of a Q component fed to the multiplier

  localparam logic [19:0] DET_EPS_RESET = 20'd4295;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_ORIGIN_Z = 2'd2,
    REG_DET_EPS  = 2'd3
  } reg_idx_e;

  // Multiplier operand pairs
  typedef enum logic [3:0] {
    MS_E1Z_E2Y, MS_E1Y_E2Z, MS_TZ_E2Y, MS_TY_E2Z,
    MS_TY_E1Z,  MS_TZ_E1Y,  MS_TZ_E1X, MS_TX_E1Z,
    MS_TX_E1Y,  MS_TY_E1X,  MS_E2X_QXL, MS_E2X_QXH,
    MS_E2Y_QYL, MS_E2Y_QYH, MS_E2Z_QZL, MS_E2Z_QZH
  } mul_sel_e;

  // Accumulator operation, registered with the product and then applied after the multiply
  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_e;

  // Controller states
  typedef enum logic [5:0] {
    ST_IDLE,
    ST_DET0, ST_DET1, ST_DETW, ST_FLIP,
    ST_U0, ST_U1, ST_UW, ST_UCHK,
    ST_QX0, ST_QX1, ST_QXW, ST_QXCHK,
    ST_QY0, ST_QY1, ST_QYW, ST_QYST,
    ST_QZ0, ST_QZ1, ST_QZW, ST_QZST,
    ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_TW, ST_TCHK,
    ST_HIT, ST_FIN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    mul_sel_e sel;
    acc_op_e  op;
    logic     flip;
    logic     st_u;
    logic     st_qx;
    logic     st_qy;
    logic     st_qz;
    logic     count;
    logic     emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic det_bad;
    logic u_bad;
    logic w_bad;
    logic t_neg;
    logic last;
    logic out_busy;
  } sts_t;

endpackage

// ----- hdl/pimrp_ctrl.sv -----
// ----------------------------------------------------------------------------
// pimrp_ctrl
// Sequencer that walks one triangle through the shared multiplier and the
// hit checks, then tallies the hit and emits the result on the last face.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pimrp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pimrp_pkg::sts_t   sts_i,
  output pimrp_pkg::cmd_t   cmd_o
);

  pimrp_pkg::state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pimrp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance through the step sequence; drop to FIN on any rejection
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pimrp_pkg::ST_IDLE:  if (in_valid_i) state_d = pimrp_pkg::ST_DET0;
      pimrp_pkg::ST_DET0:  state_d = pimrp_pkg::ST_DET1;
      pimrp_pkg::ST_DET1:  state_d = pimrp_pkg::ST_DETW;
      pimrp_pkg::ST_DETW:  state_d = pimrp_pkg::ST_FLIP;
      pimrp_pkg::ST_FLIP:  state_d = sts_i.det_bad ? pimrp_pkg::ST_FIN : pimrp_pkg::ST_U0;
      pimrp_pkg::ST_U0:    state_d = pimrp_pkg::ST_U1;
      pimrp_pkg::ST_U1:    state_d = pimrp_pkg::ST_UW;
      pimrp_pkg::ST_UW:    state_d = pimrp_pkg::ST_UCHK;
      pimrp_pkg::ST_UCHK:  state_d = sts_i.u_bad ? pimrp_pkg::ST_FIN : pimrp_pkg::ST_QX0;
      pimrp_pkg::ST_QX0:   state_d = pimrp_pkg::ST_QX1;
      pimrp_pkg::ST_QX1:   state_d = pimrp_pkg::ST_QXW;
      pimrp_pkg::ST_QXW:   state_d = pimrp_pkg::ST_QXCHK;
      pimrp_pkg::ST_QXCHK: state_d = sts_i.w_bad ? pimrp_pkg::ST_FIN : pimrp_pkg::ST_QY0;
      pimrp_pkg::ST_QY0:   state_d = pimrp_pkg::ST_QY1;
      pimrp_pkg::ST_QY1:   state_d = pimrp_pkg::ST_QYW;
      pimrp_pkg::ST_QYW:   state_d = pimrp_pkg::ST_QYST;
      pimrp_pkg::ST_QYST:  state_d = pimrp_pkg::ST_QZ0;
      pimrp_pkg::ST_QZ0:   state_d = pimrp_pkg::ST_QZ1;
      pimrp_pkg::ST_QZ1:   state_d = pimrp_pkg::ST_QZW;
      pimrp_pkg::ST_QZW:   state_d = pimrp_pkg::ST_QZST;
      pimrp_pkg::ST_QZST:  state_d = pimrp_pkg::ST_T0;
      pimrp_pkg::ST_T0:    state_d = pimrp_pkg::ST_T1;
      pimrp_pkg::ST_T1:    state_d = pimrp_pkg::ST_T2;
      pimrp_pkg::ST_T2:    state_d = pimrp_pkg::ST_T3;
      pimrp_pkg::ST_T3:    state_d = pimrp_pkg::ST_T4;
      pimrp_pkg::ST_T4:    state_d = pimrp_pkg::ST_T5;
      pimrp_pkg::ST_T5:    state_d = pimrp_pkg::ST_TW;
      pimrp_pkg::ST_TW:    state_d = pimrp_pkg::ST_TCHK;
      pimrp_pkg::ST_TCHK:  state_d = sts_i.t_neg ? pimrp_pkg::ST_FIN : pimrp_pkg::ST_HIT;
      pimrp_pkg::ST_HIT:   state_d = pimrp_pkg::ST_FIN;
      pimrp_pkg::ST_FIN: begin
        if (!sts_i.last || !sts_i.out_busy) state_d = pimrp_pkg::ST_IDLE;
      end
      default:             state_d = pimrp_pkg::ST_IDLE;
    endcase
  end

  // Drive datapath commands for the current step
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.sel     = pimrp_pkg::MS_E1Z_E2Y;
    cmd_o.op      = pimrp_pkg::ACC_HOLD;
    unique case (state_q)
      pimrp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      pimrp_pkg::ST_DET0: begin
        cmd_o.sel = pimrp_pkg::MS_E1Z_E2Y; cmd_o.op = pimrp_pkg::ACC_LOAD;
      end
      pimrp_pkg::ST_DET1: begin
        cmd_o.sel = pimrp_pkg::MS_E1Y_E2Z; cmd_o.op = pimrp_pkg::ACC_SUB;
      end
      pimrp_pkg::ST_FLIP: cmd_o.flip = 1'b1;
      pimrp_pkg::ST_U0: begin
        cmd_o.sel = pimrp_pkg::MS_TZ_E2Y; cmd_o.op = pimrp_pkg::ACC_LOAD;
      end
      pimrp_pkg::ST_U1: begin
        cmd_o.sel = pimrp_pkg::MS_TY_E2Z; cmd_o.op = pimrp_pkg::ACC_SUB;
      end
      pimrp_pkg::ST_UCHK: cmd_o.st_u = 1'b1;
      pimrp_pkg::ST_QX0: begin
        cmd_o.sel = pimrp_pkg::MS_TY_E1Z; cmd_o.op = pimrp_pkg::ACC_LOAD;
      end
      pimrp_pkg::ST_QX1: begin
        cmd_o.sel = pimrp_pkg::MS_TZ_E1Y; cmd_o.op = pimrp_pkg::ACC_SUB;
      end
      pimrp_pkg::ST_QXCHK: cmd_o.st_qx = 1'b1;
      pimrp_pkg::ST_QY0: begin
        cmd_o.sel = pimrp_pkg::MS_TZ_E1X; cmd_o.op = pimrp_pkg::ACC_LOAD;
      end
      pimrp_pkg::ST_QY1: begin
        cmd_o.sel = pimrp_pkg::MS_TX_E1Z; cmd_o.op = pimrp_pkg::ACC_SUB;
      end
      pimrp_pkg::ST_QYST: cmd_o.st_qy = 1'b1;
      pimrp_pkg::ST_QZ0: begin
        cmd_o.sel = pimrp_pkg::MS_TX_E1Y; cmd_o.op = pimrp_pkg::ACC_LOAD;
      end
      pimrp_pkg::ST_QZ1: begin
        cmd_o.sel = pimrp_pkg::MS_TY_E1X; cmd_o.op = pimrp_pkg::ACC_SUB;
      end
      pimrp_pkg::ST_QZST: cmd_o.st_qz = 1'b1;
      pimrp_pkg::ST_T0: begin
        cmd_o.sel = pimrp_pkg::MS_E2X_QXL; cmd_o.op = pimrp_pkg::ACC_LOAD;
      end
      pimrp_pkg::ST_T1: begin
        cmd_o.sel = pimrp_pkg::MS_E2X_QXH; cmd_o.op = pimrp_pkg::ACC_ADD;
      end
      pimrp_pkg::ST_T2: begin
        cmd_o.sel = pimrp_pkg::MS_E2Y_QYL; cmd_o.op = pimrp_pkg::ACC_ADD;
      end
      pimrp_pkg::ST_T3: begin
        cmd_o.sel = pimrp_pkg::MS_E2Y_QYH; cmd_o.op = pimrp_pkg::ACC_ADD;
      end
      pimrp_pkg::ST_T4: begin
        cmd_o.sel = pimrp_pkg::MS_E2Z_QZL; cmd_o.op = pimrp_pkg::ACC_ADD;
      end
      pimrp_pkg::ST_T5: begin
        cmd_o.sel = pimrp_pkg::MS_E2Z_QZH; cmd_o.op = pimrp_pkg::ACC_ADD;
      end
      pimrp_pkg::ST_HIT: cmd_o.count = 1'b1;
      pimrp_pkg::ST_FIN: cmd_o.emit = sts_i.last && !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

// ----- hdl/pimrp_dpath.sv -----
// ----------------------------------------------------------------------------
// pimrp_dpath
// Triangle datapath: edge and offset vectors, one shared 35x35 multiplier
// with a product register, a wide accumulator, the hit checks, the parity
// and crossing counter, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pimrp_dpath #(
  parameter int COUNT_WIDTH = pimrp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pimrp_pkg::cmd_t     cmd_i,
  output pimrp_pkg::sts_t     sts_o,
  input  logic signed [31:0]  origin_x_i,
  input  logic signed [31:0]  origin_y_i,
  input  logic signed [31:0]  origin_z_i,
  input  logic        [19:0]  det_epsilon_i,
  input  logic signed [31:0]  a_x_i,
  input  logic signed [31:0]  a_y_i,
  input  logic signed [31:0]  a_z_i,
  input  logic signed [31:0]  b_x_i,
  input  logic signed [31:0]  b_y_i,
  input  logic signed [31:0]  b_z_i,
  input  logic signed [31:0]  c_x_i,
  input  logic signed [31:0]  c_y_i,
  input  logic signed [31:0]  c_z_i,
  input  logic                last_face_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                inside_res_o,
  output logic        [15:0]  crossings_o
);

  localparam int VW  = pimrp_pkg::VW;
  localparam int PW  = pimrp_pkg::PW;
  localparam int MW  = pimrp_pkg::MW;
  localparam int XW  = pimrp_pkg::XW;
  localparam int AW  = pimrp_pkg::AW;
  localparam int QLO = pimrp_pkg::QLO;

  logic signed [VW-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [VW-1:0] tx_q, ty_q, tz_q;
  logic signed [PW-1:0] det_q, u_q, qx_q, qy_q, qz_q;
  logic                 last_q;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [XW-1:0] prod_d, prod_q;
  logic                 hi_q;
  pimrp_pkg::acc_op_e   op_q;
  logic signed [AW-1:0] acc_q, addend;
  logic signed [PW-1:0] acc_lo;
  logic                 det_pos;
  logic        [PW-1:0] det_abs;
  logic signed [PW:0]   uw_sum;
  logic                 parity_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic [15:0]          cross_sat;
  logic                 out_valid_q, inside_q;
  logic [15:0]          crossings_q;

  // Extend a vector component to a multiplier operand
  function automatic logic signed [MW-1:0] ext_v(input logic signed [VW-1:0] v);
    return {{(MW-VW){v[VW-1]}}, v};
  endfunction

  // Low slice of a Q component, unsigned
  function automatic logic signed [MW-1:0] q_lo(input logic signed [PW-1:0] q);
    return {{(MW-QLO){1'b0}}, q[QLO-1:0]};
  endfunction

  // High slice of a Q component, signed
  function automatic logic signed [MW-1:0] q_hi(input logic signed [PW-1:0] q);
    return {{(MW-(PW-QLO)){q[PW-1]}}, q[PW-1:QLO]};
  endfunction

  // Capture edge and offset vectors on accept; flip offsets with the determinant
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      e1x_q  <= {b_x_i[31], b_x_i} - {a_x_i[31], a_x_i};
      e1y_q  <= {b_y_i[31], b_y_i} - {a_y_i[31], a_y_i};
      e1z_q  <= {b_z_i[31], b_z_i} - {a_z_i[31], a_z_i};
      e2x_q  <= {c_x_i[31], c_x_i} - {a_x_i[31], a_x_i};
      e2y_q  <= {c_y_i[31], c_y_i} - {a_y_i[31], a_y_i};
      e2z_q  <= {c_z_i[31], c_z_i} - {a_z_i[31], a_z_i};
      tx_q   <= {origin_x_i[31], origin_x_i} - {a_x_i[31], a_x_i};
      ty_q   <= {origin_y_i[31], origin_y_i} - {a_y_i[31], a_y_i};
      tz_q   <= {origin_z_i[31], origin_z_i} - {a_z_i[31], a_z_i};
      last_q <= last_face_i;
    end else if (cmd_i.flip) begin
      det_q <= det_abs;
      if (!det_pos) begin
        tx_q <= -tx_q;
        ty_q <= -ty_q;
        tz_q <= -tz_q;
      end
    end
    if (cmd_i.st_u)  u_q  <= acc_lo;
    if (cmd_i.st_qx) qx_q <= acc_lo;
    if (cmd_i.st_qy) qy_q <= acc_lo;
    if (cmd_i.st_qz) qz_q <= acc_lo;
  end

  // Select multiplier operands
  always_comb begin
    mul_a = ext_v(e1z_q);
    mul_b = ext_v(e2y_q);
    case (cmd_i.sel)
      pimrp_pkg::MS_E1Z_E2Y: begin mul_a = ext_v(e1z_q); mul_b = ext_v(e2y_q); end
      pimrp_pkg::MS_E1Y_E2Z: begin mul_a = ext_v(e1y_q); mul_b = ext_v(e2z_q); end
      pimrp_pkg::MS_TZ_E2Y:  begin mul_a = ext_v(tz_q);  mul_b = ext_v(e2y_q); end
      pimrp_pkg::MS_TY_E2Z:  begin mul_a = ext_v(ty_q);  mul_b = ext_v(e2z_q); end
      pimrp_pkg::MS_TY_E1Z:  begin mul_a = ext_v(ty_q);  mul_b = ext_v(e1z_q); end
      pimrp_pkg::MS_TZ_E1Y:  begin mul_a = ext_v(tz_q);  mul_b = ext_v(e1y_q); end
      pimrp_pkg::MS_TZ_E1X:  begin mul_a = ext_v(tz_q);  mul_b = ext_v(e1x_q); end
      pimrp_pkg::MS_TX_E1Z:  begin mul_a = ext_v(tx_q);  mul_b = ext_v(e1z_q); end
      pimrp_pkg::MS_TX_E1Y:  begin mul_a = ext_v(tx_q);  mul_b = ext_v(e1y_q); end
      pimrp_pkg::MS_TY_E1X:  begin mul_a = ext_v(ty_q);  mul_b = ext_v(e1x_q); end
      pimrp_pkg::MS_E2X_QXL: begin mul_a = ext_v(e2x_q); mul_b = q_lo(qx_q);   end
      pimrp_pkg::MS_E2X_QXH: begin mul_a = ext_v(e2x_q); mul_b = q_hi(qx_q);   end
      pimrp_pkg::MS_E2Y_QYL: begin mul_a = ext_v(e2y_q); mul_b = q_lo(qy_q);   end
      pimrp_pkg::MS_E2Y_QYH: begin mul_a = ext_v(e2y_q); mul_b = q_hi(qy_q);   end
      pimrp_pkg::MS_E2Z_QZL: begin mul_a = ext_v(e2z_q); mul_b = q_lo(qz_q);   end
      pimrp_pkg::MS_E2Z_QZH: begin mul_a = ext_v(e2z_q); mul_b = q_hi(qz_q);   end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Register the product with its pending accumulator operation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= pimrp_pkg::ACC_HOLD;
      hi_q <= 1'b0;
    end else begin
      op_q <= cmd_i.op;
      hi_q <= (cmd_i.sel == pimrp_pkg::MS_E2X_QXH) || (cmd_i.sel == pimrp_pkg::MS_E2Y_QYH)
           || (cmd_i.sel == pimrp_pkg::MS_E2Z_QZH);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Accumulate; high partial products weigh 2^QLO
  assign addend = hi_q ? {prod_q[AW-QLO-1:0], {QLO{1'b0}}}
                       : {{(AW-XW){prod_q[XW-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    case (op_q)
      pimrp_pkg::ACC_LOAD: acc_q <= addend;
      pimrp_pkg::ACC_ADD:  acc_q <= acc_q + addend;
      pimrp_pkg::ACC_SUB:  acc_q <= acc_q - addend;
      default: ;
    endcase
  end

  // Checks on the finished accumulator value
  assign acc_lo  = acc_q[PW-1:0];
  assign det_pos = !acc_q[AW-1] && (acc_q != '0);
  assign det_abs = det_pos ? acc_lo : -acc_lo;
  assign uw_sum  = {u_q[PW-1], u_q} + {acc_lo[PW-1], acc_lo};

  always_comb begin
    sts_o.det_bad  = (det_abs == '0) || (det_abs < {{(PW-20){1'b0}}, det_epsilon_i});
    sts_o.u_bad    = acc_q[AW-1] || (acc_lo > det_q);
    sts_o.w_bad    = acc_q[AW-1] || (uw_sum > {det_q[PW-1], det_q});
    sts_o.t_neg    = acc_q[AW-1];
    sts_o.last     = last_q;
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  // Saturate the reported count to the result field
  if (COUNT_WIDTH > 16) begin : g_sat
    assign cross_sat = (|cnt_q[COUNT_WIDTH-1:16]) ? 16'hFFFF : cnt_q[15:0];
  end else begin : g_nosat
    assign cross_sat = 16'(cnt_q);
  end

  // Tally hits; clear on emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
      cnt_q    <= '0;
    end else if (cmd_i.emit) begin
      parity_q <= 1'b0;
      cnt_q    <= '0;
    end else if (cmd_i.count) begin
      parity_q <= ~parity_q;
      if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      inside_q    <= parity_q;
      crossings_q <= cross_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;
  assign crossings_o  = crossings_q;

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q) else $error("result not presented after emit");

  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (cnt_q == '0) && !parity_q) else $error("tally not cleared");

  a_count_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count && !cmd_i.emit |=> parity_q != $past(parity_q))
    else $error("parity did not toggle on hit");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.emit |=> cnt_q >= $past(cnt_q)) else $error("crossing count decreased");

endmodule

// ----- hdl/point_in_mesh_ray_parity.sv -----
// ----------------------------------------------------------------------------
// point_in_mesh_ray_parity
// Point-in-closed-mesh test by +x ray crossing parity over streamed triangles.
// ----------------------------------------------------------------------------
// Usage:
//   Set the query point and determinant threshold over the APB port, then
//   stream the mesh triangles on the input channel (in_valid_i/in_ready_o),
//   one vertex triple per transaction, with last_face_i on the final one.
//   Each triangle gets an exact Moller-Trumbore test against the ray.
//   After the last face one result transaction (inside_res_o, crossings_o)
//   is offered on out_valid_o/out_ready_i and the tally starts over.
// Sequencing:
//   A new triangle is accepted only after the previous one has been
//   rejected or tallied. Up to sixteen products pass one by one through a
//   single 35x35 multiplier and its product register, and each run of
//   products ends in a wait state before the accumulator is read.
// Stall and reset:
//   The result sits in an output register; new triangles are accepted while
//   it waits. Only a further last face stalls until the receiver takes it.
//   Reset clears the tally, drops out_valid_o and restores the registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_mesh_ray_parity #(
  parameter int COUNT_WIDTH = pimrp_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [3:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] c_x_i,
  input  logic signed [31:0] c_y_i,
  input  logic signed [31:0] c_z_i,
  input  logic               last_face_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               inside_res_o,
  output logic        [15:0] crossings_o
);

  logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;
  logic        [19:0] det_eps_q;
  logic               wr_en;
  pimrp_pkg::reg_idx_e reg_idx;
  pimrp_pkg::cmd_t    cmd;
  pimrp_pkg::sts_t    sts;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = pimrp_pkg::reg_idx_e'(paddr[3:2]);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      det_eps_q  <= pimrp_pkg::DET_EPS_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        pimrp_pkg::REG_ORIGIN_X: origin_x_q <= pwdata;
        pimrp_pkg::REG_ORIGIN_Y: origin_y_q <= pwdata;
        pimrp_pkg::REG_ORIGIN_Z: origin_z_q <= pwdata;
        pimrp_pkg::REG_DET_EPS:  det_eps_q  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (reg_idx)
      pimrp_pkg::REG_ORIGIN_X: prdata = origin_x_q;
      pimrp_pkg::REG_ORIGIN_Y: prdata = origin_y_q;
      pimrp_pkg::REG_ORIGIN_Z: prdata = origin_z_q;
      pimrp_pkg::REG_DET_EPS:  prdata = {12'd0, det_eps_q};
      default:                 prdata = '0;
    endcase
  end

  pimrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pimrp_dpath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .origin_x_i    (origin_x_q),
    .origin_y_i    (origin_y_q),
    .origin_z_i    (origin_z_q),
    .det_epsilon_i (det_eps_q),
    .a_x_i         (a_x_i),
    .a_y_i         (a_y_i),
    .a_z_i         (a_z_i),
    .b_x_i         (b_x_i),
    .b_y_i         (b_y_i),
    .b_z_i         (b_z_i),
    .c_x_i         (c_x_i),
    .c_y_i         (c_y_i),
    .c_z_i         (c_z_i),
    .last_face_i   (last_face_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .inside_res_o  (inside_res_o),
    .crossings_o   (crossings_o)
  );

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for point_in_mesh_ray_parity: streams triangle meshes,
// predicts the ray crossing parity and count per mesh and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] v [9];   // ax ay az bx by bz cx cy cz
    logic               last;
  } tri_t;

  typedef struct {
    logic        is_in;
    logic [15:0] crossings;
  } tally_t;

  // Mesh tally predictor and store of expected results
  class mesh_tally;
    logic signed [31:0] org [3];
    logic [19:0]        eps;
    logic               parity;
    logic [15:0]        count;
    tally_t             tally_q [$];

    function void reset_state();
      org[0] = 0; org[1] = 0; org[2] = 0;
      eps = pimrp_pkg::DET_EPS_RESET;
      parity = 0;
      count = 0;
    endfunction

    function void set_reg(pimrp_pkg::reg_idx_e idx, logic [31:0] val);
      case (idx)
        pimrp_pkg::REG_ORIGIN_X: org[0] = val;
        pimrp_pkg::REG_ORIGIN_Y: org[1] = val;
        pimrp_pkg::REG_ORIGIN_Z: org[2] = val;
        pimrp_pkg::REG_DET_EPS:  eps = val[19:0];
        default: ;
      endcase
    endfunction

    function bit ray_crosses(tri_t t);
      wide_t e1x, e1y, e1z, e2x, e2y, e2z, tx, ty, tz;
      wide_t det, u, qx, qy, qz, tt, a0, a1, a2;
      a0 = t.v[0]; a1 = t.v[1]; a2 = t.v[2];
      e1x = wide_t'(t.v[3]) - a0; e1y = wide_t'(t.v[4]) - a1;
      e1z = wide_t'(t.v[5]) - a2;
      e2x = wide_t'(t.v[6]) - a0; e2y = wide_t'(t.v[7]) - a1;
      e2z = wide_t'(t.v[8]) - a2;
      det = e1z * e2y - e1y * e2z;
      // make the determinant positive by flipping the offset vector
      if (det > 0) begin
        tx = wide_t'(org[0]) - a0; ty = wide_t'(org[1]) - a1; tz = wide_t'(org[2]) - a2;
      end else begin
        tx = a0 - wide_t'(org[0]); ty = a1 - wide_t'(org[1]); tz = a2 - wide_t'(org[2]);
        det = -det;
      end
      if (det == 0 || det < wide_t'({1'b0, eps})) return 0;
      u = tz * e2y - ty * e2z;
      if (u < 0 || u > det) return 0;
      qx = ty * e1z - tz * e1y;
      qy = tz * e1x - tx * e1z;
      qz = tx * e1y - ty * e1x;
      if (qx < 0 || u + qx > det) return 0;
      tt = e2x * qx + e2y * qy + e2z * qz;
      return tt >= 0;
    endfunction

    function void note_triangle(tri_t t);
      tally_t r;
      if (ray_crosses(t)) begin
        parity = ~parity;
        if (count != 16'hFFFF) count++;
      end
      if (t.last) begin
        r.is_in = parity;
        r.crossings = count;
        tally_q = {tally_q, r};
        parity = 0;
        count = 0;
      end
    endfunction

    function string check_result(logic is_in, logic [15:0] crossings);
      tally_t r;
      string  msg;
      msg = "";
      if (tally_q.size() == 0) return "result with no mesh pending";
      r = tally_q.pop_front();
      if (is_in !== r.is_in)
        msg = $sformatf("inside_res %0b, expected %0b ", is_in, r.is_in);
      if (crossings !== r.crossings)
        msg = {msg, $sformatf("crossings %0d, expected %0d", crossings, r.crossings)};
      return msg;
    endfunction

    function int pending();
      return tally_q.size();
    endfunction
  endclass

  localparam int LIMIT = 1_500_000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  tri_t        drv;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic        inside_res_o;
  logic [15:0] crossings_o;

  mesh_tally sb;
  tri_t      stim_q [$];
  int        errors = 0;
  int        cycles = 0;
  bit        calm = 0;
  string     msg;

  initial begin
    for (int i = 0; i < 9; i++) drv.v[i] = '0;
    drv.last = 0;
    sb = new();
    sb.reset_state();
  end

  point_in_mesh_ray_parity DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .a_x_i(drv.v[0]), .a_y_i(drv.v[1]), .a_z_i(drv.v[2]),
    .b_x_i(drv.v[3]), .b_y_i(drv.v[4]), .b_z_i(drv.v[5]),
    .c_x_i(drv.v[6]), .c_y_i(drv.v[7]), .c_z_i(drv.v[8]),
    .last_face_i(drv.last),
    .out_valid_o, .out_ready_i, .inside_res_o, .crossings_o
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  task automatic report(string s);
    $display("ERROR @%0t: %s", $realtime, s);
    errors++;
  endtask

  // Note accepted triangles and check result transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_triangle(drv);
      if (out_valid_o && out_ready_i) begin
        msg = sb.check_result(inside_res_o, crossings_o);
        if (msg != "") report(msg);
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: stall in random bursts until the calm tail
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_ready_i <= 1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  task automatic reg_write(pimrp_pkg::reg_idx_e idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  // Wait for every pending result, then let the last triangle drain
  task automatic drain();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [19:0] e);
    drain();
    reg_write(pimrp_pkg::REG_ORIGIN_X, x);
    reg_write(pimrp_pkg::REG_ORIGIN_Y, y);
    reg_write(pimrp_pkg::REG_ORIGIN_Z, z);
    reg_write(pimrp_pkg::REG_DET_EPS, {12'd0, e});
  endtask

  // Drive every queued triangle, with random gaps unless calm
  task automatic run_items();
    tri_t t;
    while (stim_q.size() != 0) begin
      t = stim_q.pop_front();
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_valid_i <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      in_valid_i <= 1;
      drv <= t;
      do @(posedge clk_i); while (!in_ready_o);
    end
    in_valid_i <= 0;
  endtask

  task automatic add_tri(int ax, int ay, int az, int bx, int by, int bz,
                         int cx, int cy, int cz, bit last);
    tri_t t;
    t.v[0] = ax; t.v[1] = ay; t.v[2] = az;
    t.v[3] = bx; t.v[4] = by; t.v[5] = bz;
    t.v[6] = cx; t.v[7] = cy; t.v[8] = cz;
    t.last = last;
    stim_q = {stim_q, t};
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // One random mesh: mostly small triangles around the query point
  task automatic add_mesh();
    tri_t t;
    int   n, mode, span;
    n = $urandom_range(1, 8);
    for (int f = 0; f < n; f++) begin
      mode = $urandom_range(0, 9);
      span = ($urandom_range(0, 3) == 0) ? 8 : 4 << 16;
      for (int k = 0; k < 9; k++) begin
        if (mode == 0) t.v[k] = $urandom();
        else if (mode == 1) t.v[k] = pick_extreme();
        else if (k % 3 == 0)
          t.v[k] = sb.org[0] + $signed($urandom_range(0, 4 * span)) - span;
        else
          t.v[k] = sb.org[k % 3] + $signed($urandom_range(0, 2 * span)) - span;
      end
      t.last = (f == n - 1);
      stim_q = {stim_q, t};
    end
  endtask

  localparam int ONE = 65536;

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: hits, misses behind, edge hit, zero determinant, extremes
    add_tri(ONE, -ONE, -ONE, ONE, ONE, -ONE, ONE, -ONE, ONE, 1);
    add_tri(-ONE, -ONE, -ONE, -ONE, ONE, -ONE, -ONE, -ONE, ONE, 1);
    add_tri(ONE, -ONE, -ONE, ONE, -ONE, ONE, ONE, ONE, -ONE, 0);
    add_tri(2*ONE, -ONE, -ONE, 2*ONE, ONE, -ONE, 2*ONE, -ONE, 2*ONE, 1);
    add_tri(ONE, 0, 0, 2*ONE, ONE, ONE, 3*ONE, 2*ONE, 2*ONE, 1);
    add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tri(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
            32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
            32'h7FFFFFFF, 1);
    add_tri(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
            32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
            32'h80000000, 1);
    // closed tetrahedron around the origin
    add_tri(-ONE, -ONE, -ONE, 3*ONE, -ONE, -ONE, -ONE, 3*ONE, -ONE, 0);
    add_tri(-ONE, -ONE, -ONE, 3*ONE, -ONE, -ONE, -ONE, -ONE, 3*ONE, 0);
    add_tri(-ONE, -ONE, -ONE, -ONE, 3*ONE, -ONE, -ONE, -ONE, 3*ONE, 0);
    add_tri(3*ONE, -ONE, -ONE, -ONE, 3*ONE, -ONE, -ONE, -ONE, 3*ONE, 1);
    run_items();

    // zero determinant with no threshold, tiny determinant against it
    set_point(0, 0, 0, 0);
    add_tri(ONE, 0, 0, ONE, ONE, ONE, ONE, 2*ONE, 2*ONE, 1);
    add_tri(ONE, -1, -1, ONE, 1, -1, ONE, -1, 1, 1);
    run_items();
    set_point(0, 0, 0, 20'hFFFFF);
    add_tri(ONE, -1, -1, ONE, 1, -1, ONE, -1, 1, 1);
    add_tri(ONE, -ONE, -ONE, ONE, ONE, -ONE, ONE, -ONE, ONE, 1);
    run_items();

    // random meshes across several query points and thresholds
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_point(0, 0, 0, pimrp_pkg::DET_EPS_RESET);
        1: set_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        2: set_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'hFFFFF);
        default: set_point($urandom(), $urandom(), $urandom(), $urandom_range(0, 20'hFFFFF));
      endcase
      if (ph == 5) calm = 1;
      while (stim_q.size() < 225) add_mesh();
      run_items();
    end

    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
